### design/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// shared constants, types and helpers for the integer to ascii converter
// ---------------------------------------------------------------------------
package itoa_pkg;

   // word width and derived digit counts
   localparam int VALUE_BITS  = 32;
   localparam int HEX_DIGITS  = (VALUE_BITS + 3) / 4;
   localparam int DEC_DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int IDX_W       = $clog2(VALUE_BITS);
   localparam int BCD_W       = DEC_DIGITS * 4;
   localparam int HEX_W       = HEX_DIGITS * 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // radix mode codes on the request port
   localparam logic [1:0] MODE_SDEC = 2'd0;
   localparam logic [1:0] MODE_HEX  = 2'd1;
   localparam logic [1:0] MODE_BIN  = 2'd2;
   localparam logic [1:0] MODE_UDEC = 2'd3;

   // ascii codes
   localparam logic [6:0] CHAR_MINUS   = 7'h2d;
   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_A_LOWER = 7'h61;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_BIN
   } radix_type;

   // classified word passed from front to back
   typedef struct packed {
      logic [VALUE_BITS-1:0] mag;
      radix_type             radix;
      logic                  minus;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CONV,
      BK_SIGN,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

   // one digit value to its ascii character
   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_A_LOWER + {3'b000, d} - 7'd10;
      end
      return c;
   endfunction

endpackage

### design/integer_to_ascii_radix.sv
// a taken word waits in the queue; the back end pops it, runs the bcd conversion for a decimal word,
// sends '-' first for a negative signed decimal word, skips the leading zero digits and then emits
// the digits; digits go out one character per cycle while the output does not stall, and the queue
// takes new words while the back end is still busy with an earlier one, until it is full
// reset clears the queue, the sequencer and the output valid; no other state
// ---------------------------------------------------------------------------
// integer_to_ascii_radix
// converts a 32-bit integer to ascii digits, one character word at a time
// ---------------------------------------------------------------------------
module integer_to_ascii_radix (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [itoa_pkg::VALUE_BITS-1:0] req_value,
   input  logic [1:0]                             req_radix_mode,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [6:0]                             rsp_character,
   output logic                                   rsp_last
);
   import itoa_pkg::*;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   item_type push_item;
   item_type pop_item;

   // front: accept and classify
   itoa_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_radix_mode (req_radix_mode),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   // queue between the two halves
   itoa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (pop_item)
   );

   // back: convert and emit
   itoa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

### design/itoa_front.sv
// ---------------------------------------------------------------------------
// itoa_front
// takes request words, picks the radix and forms the magnitude and sign
// ---------------------------------------------------------------------------
module itoa_front (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [itoa_pkg::VALUE_BITS-1:0] req_value,
   input  logic [1:0]                       req_radix_mode,
   input  logic                             q_full,
   output logic                             q_push,
   output itoa_pkg::item_type               q_item
);
   import itoa_pkg::*;

   logic [VALUE_BITS-1:0] word;

   assign word      = req_value;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // classify the word
   always_comb begin
      q_item.mag   = word;
      q_item.minus = 1'b0;
      q_item.radix = RADIX_DEC;
      case (req_radix_mode)
         MODE_SDEC: begin
            q_item.minus = word[VALUE_BITS-1];
            if (word[VALUE_BITS-1]) begin
               q_item.mag = (~word) + {{(VALUE_BITS-1){1'b0}}, 1'b1};
            end
         end
         MODE_HEX:  q_item.radix = RADIX_HEX;
         MODE_BIN:  q_item.radix = RADIX_BIN;
         default:   q_item.radix = RADIX_DEC;
      endcase
   end

endmodule

### design/itoa_queue.sv
// ---------------------------------------------------------------------------
// itoa_queue
// short fifo between the front and the back
// ---------------------------------------------------------------------------
module itoa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  itoa_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output itoa_pkg::item_type pop_item
);
   import itoa_pkg::*;

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/itoa_back.sv
// ---------------------------------------------------------------------------
// itoa_back
// converts one queued word to digits and sends them msb first
// ---------------------------------------------------------------------------
module itoa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  itoa_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [6:0]         rsp_character,
   output logic               rsp_last
);
   import itoa_pkg::*;

   back_state_type        state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   radix_type             radix_ff, radix_in;
   logic                  minus_ff, minus_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [6:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  conv_done;
   logic [3:0]            digit;
   logic [HEX_W-1:0]      hex_word;
   logic [BCD_W-1:0]      bcd_adj;
   logic [IDX_W-1:0]      top_idx;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign conv_done     = (cnt_ff == IDX_W'(VALUE_BITS - 1));
   assign hex_word      = HEX_W'(mag_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // current digit at the scan index
   always_comb begin
      case (radix_ff)
         RADIX_HEX: digit = hex_word[idx_ff*4 +: 4];
         RADIX_BIN: digit = {3'b000, mag_ff[idx_ff]};
         default:   digit = bcd_ff[idx_ff*4 +: 4];
      endcase
   end

   // add-three correction on each bcd digit
   always_comb begin
      for (int k = 0; k < DEC_DIGITS; k++) begin
         if (bcd_ff[k*4 +: 4] >= 4'd5) begin
            bcd_adj[k*4 +: 4] = bcd_ff[k*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[k*4 +: 4] = bcd_ff[k*4 +: 4];
         end
      end
   end

   // highest digit position of the incoming word
   always_comb begin
      case (q_item.radix)
         RADIX_HEX: top_idx = IDX_W'(HEX_DIGITS - 1);
         RADIX_BIN: top_idx = IDX_W'(VALUE_BITS - 1);
         default:   top_idx = IDX_W'(DEC_DIGITS - 1);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_item.radix == RADIX_DEC) ? BK_CONV : BK_SCAN;
            end
         end
         BK_CONV: begin
            if (conv_done) begin
               state_in = minus_ff ? BK_SIGN : BK_SCAN;
            end
         end
         BK_SIGN: begin
            if (out_free) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (digit != 4'd0 || idx_ff == '0) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free && idx_ff == '0) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and output word
   always_comb begin
      q_pop        = 1'b0;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      radix_in     = radix_ff;
      minus_in     = minus_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               mag_in   = q_item.mag;
               radix_in = q_item.radix;
               minus_in = q_item.minus;
               bcd_in   = '0;
               cnt_in   = '0;
               idx_in   = top_idx;
            end
         end
         BK_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         BK_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         BK_SCAN: begin
            if (digit == 4'd0 && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(digit);
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      radix_ff    <= radix_in;
      minus_ff    <= minus_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

### tb/itoa_char_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// itoa_char_checker
// watches both channels of the integer to ascii converter, predicts the
// character words of every accepted request and compares them in order
// ---------------------------------------------------------------------------
module itoa_char_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [itoa_pkg::VALUE_BITS-1:0] req_value,
   input  logic [1:0]                      req_radix_mode,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [6:0]                      rsp_character,
   input  logic                            rsp_last,
   output int                              error_count,
   output int                              chars_pending
);
   import itoa_pkg::*;

   typedef struct {
      logic [6:0] ch;
      logic       is_last;
   } char_word_type;

   char_word_type expected_chars[$];

   initial begin
      error_count   = 0;
      chars_pending = 0;
   end

   // queue the characters one number turns into, most significant first
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] word,
                                          input logic [1:0]            mode);
      logic [VALUE_BITS-1:0] mag;
      logic [5:0]            base;
      logic [3:0]            digits [VALUE_BITS];
      int                    count;
      logic                  negative;
      char_word_type         w;
      mag      = word;
      base     = 6'd10;
      negative = 1'b0;
      count    = 0;
      case (mode)
         MODE_SDEC: begin
            // two's complement negation also covers the most negative word
            if (word[VALUE_BITS-1]) begin
               negative = 1'b1;
               mag      = -word;
            end
         end
         MODE_HEX: begin
            base = 6'd16;
         end
         MODE_BIN: begin
            base = 6'd2;
         end
         default: begin
         end
      endcase
      // least significant digit first, at least one digit
      do begin
         digits[count] = 4'(mag % base);
         count++;
         mag = mag / base;
      end while (mag != 0);
      if (negative) begin
         w.ch      = CHAR_MINUS;
         w.is_last = 1'b0;
         expected_chars.push_back(w);
      end
      for (int i = count - 1; i >= 0; i--) begin
         if (digits[i] < 4'd10) begin
            w.ch = CHAR_ZERO + 7'(digits[i]);
         end else begin
            w.ch = CHAR_A_LOWER + 7'(digits[i]) - 7'd10;
         end
         w.is_last = (i == 0);
         expected_chars.push_back(w);
      end
   endfunction

   // predict on request words, compare on result words
   always @(posedge clock) begin
      char_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_digits(req_value, req_radix_mode);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word, expected none, actual char %h last %b",
                        $time, rsp_character, rsp_last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.ch) begin
                  error_count++;
                  $display("%0t: character mismatch, expected %h actual %h",
                           $time, want.ch, rsp_character);
               end
               if (rsp_last !== want.is_last) begin
                  error_count++;
                  $display("%0t: last flag mismatch, expected %b actual %b",
                           $time, want.is_last, rsp_last);
               end
            end
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

### tb/tb_integer_to_ascii_radix.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_integer_to_ascii_radix
// drives directed and random numbers in all radix modes into the converter,
// with random idling on both channels, a long output hold-off and a drain
// pause; the checker predicts and compares every character word
// ---------------------------------------------------------------------------
module tb_integer_to_ascii_radix;
   import itoa_pkg::*;

   localparam int RANDOM_WORDS = 270;
   localparam int HOLD_AT      = 60;
   localparam int DRAIN_AT     = 120;
   localparam int QUIET_FROM   = 220;
   localparam int HOLD_CYCLES  = 300;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value;
   logic [1:0]            req_radix_mode;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [6:0]            rsp_character;
   logic                  rsp_last;
   int                    char_errors;
   int                    chars_pending;
   bit                    long_hold_req = 1'b0;
   bit                    quiet_tail    = 1'b0;

   always #10 clock = ~clock;

   integer_to_ascii_radix DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_radix_mode (req_radix_mode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last)
   );

   itoa_char_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_radix_mode (req_radix_mode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .error_count    (char_errors),
      .chars_pending  (chars_pending)
   );

   // offer one number and hold it until the converter takes it
   task automatic send_number(input logic [VALUE_BITS-1:0] v, input logic [1:0] m);
      req_valid      <= 1'b1;
      req_value      <= v;
      req_radix_mode <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mix of full-range, short, small and negative numbers
   function automatic logic [VALUE_BITS-1:0] random_number();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 4))
         0:       v = $urandom;
         1:       v = $urandom_range(0, 99);
         2:       v = $urandom >> $urandom_range(0, 31);
         3:       v = -($urandom_range(1, 1000));
         default: v = ~($urandom >> $urandom_range(0, 31));
      endcase
      return v;
   endfunction

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_value      <= '0;
      req_radix_mode <= MODE_SDEC;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero, all ones and the most negative word in every mode, the most positive word in three
      send_number(32'h0000_0000, MODE_SDEC);
      send_number(32'h0000_0000, MODE_HEX);
      send_number(32'h0000_0000, MODE_BIN);
      send_number(32'h0000_0000, MODE_UDEC);
      send_number(32'hffff_ffff, MODE_SDEC);
      send_number(32'hffff_ffff, MODE_HEX);
      send_number(32'hffff_ffff, MODE_BIN);
      send_number(32'hffff_ffff, MODE_UDEC);
      send_number(32'h8000_0000, MODE_SDEC);
      send_number(32'h8000_0000, MODE_HEX);
      send_number(32'h8000_0000, MODE_BIN);
      send_number(32'h8000_0000, MODE_UDEC);
      send_number(32'h7fff_ffff, MODE_SDEC);
      send_number(32'h7fff_ffff, MODE_HEX);
      send_number(32'h7fff_ffff, MODE_BIN);
      // digit boundaries and letters
      send_number(32'd1, MODE_BIN);
      send_number(32'd9, MODE_SDEC);
      send_number(32'd10, MODE_SDEC);
      send_number(32'd15, MODE_HEX);
      send_number(32'd16, MODE_HEX);
      send_number(-32'sd7, MODE_SDEC);
      send_number(32'hdead_beef, MODE_HEX);
      send_number(32'h0abc_def0, MODE_HEX);

      // random numbers with idling, a long hold-off and a drain pause
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == HOLD_AT) begin
            long_hold_req = 1'b1;
         end
         if (n == QUIET_FROM) begin
            quiet_tail = 1'b1;
         end
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (chars_pending == 0);
            @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         send_number(random_number(), 2'($urandom_range(0, 3)));
      end
      req_valid <= 1'b0;

      // drain the remaining characters, then a short settle
      @(posedge clock);
      wait (chars_pending == 0);
      repeat (60) @(posedge clock);
      if (char_errors == 0 && chars_pending == 0) begin
         $display("** integer_to_ascii_radix: PASSED **");
      end else begin
         $display("** integer_to_ascii_radix: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("** integer_to_ascii_radix: FAILED **");
      $finish;
   end

endmodule

### integer_to_ascii_radix.f
design/itoa_pkg.sv
design/itoa_front.sv
design/itoa_queue.sv
design/itoa_back.sv
design/integer_to_ascii_radix.sv
tb/itoa_char_checker.sv
tb/tb_integer_to_ascii_radix.sv
